// File: design/lacam_pkg.sv
// Shared constants and types for the look-at camera transform.
`timescale 1ns / 1ps
package lacam_pkg;
  localparam int WORD_W   = 32;
  localparam int UNIT_SH  = ((60 - WORD_W) < 30) ? (60 - WORD_W) : 30;
  localparam int UNIT_W   = UNIT_SH + 2;
  localparam int UP_W     = UNIT_W + 1;
  localparam int NIN_W    = ((WORD_W + 1) > (2 * UNIT_SH + 3)) ? (WORD_W + 1)
                                                               : (2 * UNIT_SH + 3);
  localparam int LIM_W    = 30;
  localparam int SQ_W     = 2 * LIM_W;
  localparam int SS_W     = SQ_W + 2;
  localparam int RT_N     = LIM_W + 1;
  localparam int QB       = UNIT_SH + 1;
  localparam int NUM_W    = LIM_W + UNIT_SH + 1;
  localparam int SH_W     = $clog2(NIN_W - LIM_W + 1);
  localparam int NORM_LAT = 7 + RT_N + QB;
  localparam int PR_W     = WORD_W + UP_W;
  localparam int SUM_W    = PR_W + 2;
  localparam int DIF_W    = SUM_W + 1;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] pt;
    logic [2:0][WORD_W-1:0] pos;
    logic [2:0][UNIT_W-1:0] lk;
  } carry_t;
endpackage

// File: design/lacam_norm.sv
// Pipelined vector normalizer: prescale, sum of squares, root, divide.
`timescale 1ns / 1ps
module lacam_norm (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2:0][lacam_pkg::NIN_W-1:0]    vec_i,
  output logic [2:0][lacam_pkg::UNIT_W-1:0]   unit_o
);
  import lacam_pkg::*;

  typedef struct packed {
    logic [2:0][LIM_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } nside_t;

  logic [2:0][NIN_W-1:0]  mag1_q, mag2_q;
  logic [2:0]             neg1_q, neg2_q;
  logic [SH_W-1:0]        sh2_q;
  logic [NIN_W-1:0]       mx;
  logic [SH_W-1:0]        sh_d;
  nside_t                 sd3_q, sd4_q, sd5_q;
  logic [2:0][SQ_W-1:0]   sq4_q;
  logic [SS_W-1:0]        ss5_q;
  logic [SS_W-1:0]        ra_q [RT_N];
  logic [SS_W-1:0]        rr_q [RT_N];
  nside_t                 rs_q [RT_N];
  logic [RT_N-1:0]        n0;
  logic [2:0][NUM_W-1:0]  num;
  logic [RT_N-1:0]        dn_q    [QB+1];
  logic [2:0][RT_N-1:0]   drem_q  [QB+1];
  logic [2:0][QB-1:0]     dlow_q  [QB+1];
  logic [2:0][QB-1:0]     dq_q    [QB+1];
  logic [2:0]             dneg_q  [QB+1];
  logic                   dzero_q [QB+1];
  logic [2:0][UNIT_W-1:0] unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg1_q[k] <= vec_i[k][NIN_W-1];
        mag1_q[k] <= vec_i[k][NIN_W-1] ? (~vec_i[k] + NIN_W'(1)) : vec_i[k];
      end
    end
  end

  always_comb begin
    mx = mag1_q[0];
    if (mag1_q[1] > mx) mx = mag1_q[1];
    if (mag1_q[2] > mx) mx = mag1_q[2];
    sh_d = '0;
    for (int k = LIM_W; k < NIN_W; k++) begin
      if (mx[k]) sh_d = SH_W'(k - LIM_W + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sh2_q  <= sh_d;
      for (int k = 0; k < 3; k++) begin
        sd3_q.mag[k] <= LIM_W'(mag2_q[k] >> sh2_q);
        sq4_q[k]     <= SQ_W'(sd3_q.mag[k] * sd3_q.mag[k]);
      end
      sd3_q.neg  <= neg2_q;
      sd3_q.zero <= (mag2_q == '0);
      sd4_q      <= sd3_q;
      ss5_q      <= SS_W'(sq4_q[0]) + SS_W'(sq4_q[1]) + SS_W'(sq4_q[2]);
      sd5_q      <= sd4_q;
    end
  end

  for (genvar j = 0; j < RT_N; j++) begin : g_rt
    localparam logic [SS_W-1:0] BIT = SS_W'(1) << (2 * (RT_N - 1 - j));
    logic [SS_W-1:0] a_in, r_in;
    nside_t          s_in;
    logic [SS_W:0]   trial;
    if (j == 0) begin : g_first
      assign a_in = ss5_q;
      assign r_in = '0;
      assign s_in = sd5_q;
    end else begin : g_next
      assign a_in = ra_q[j-1];
      assign r_in = rr_q[j-1];
      assign s_in = rs_q[j-1];
    end
    assign trial = {1'b0, r_in} + {1'b0, BIT};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q[j] <= s_in;
        if ({1'b0, a_in} >= trial) begin
          ra_q[j] <= SS_W'({1'b0, a_in} - trial);
          rr_q[j] <= (r_in >> 1) + BIT;
        end else begin
          ra_q[j] <= a_in;
          rr_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign n0 = rr_q[RT_N-1][RT_N-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = NUM_W'({rs_q[RT_N-1].mag[k], {UNIT_SH{1'b0}}}) + NUM_W'(n0 >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_q[0]    <= n0;
      dneg_q[0]  <= rs_q[RT_N-1].neg;
      dzero_q[0] <= rs_q[RT_N-1].zero;
      dq_q[0]    <= '0;
      for (int k = 0; k < 3; k++) begin
        drem_q[0][k] <= RT_N'(num[k] >> QB);
        dlow_q[0][k] <= num[k][QB-1:0];
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_dv
    logic [2:0][RT_N:0] rsh;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rsh[k] = {drem_q[j-1][k], dlow_q[j-1][k][QB-1]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dn_q[j]    <= dn_q[j-1];
        dneg_q[j]  <= dneg_q[j-1];
        dzero_q[j] <= dzero_q[j-1];
        for (int k = 0; k < 3; k++) begin
          dlow_q[j][k] <= dlow_q[j-1][k] << 1;
          if (rsh[k] >= {1'b0, dn_q[j-1]}) begin
            drem_q[j][k] <= RT_N'(rsh[k] - {1'b0, dn_q[j-1]});
            dq_q[j][k]   <= {dq_q[j-1][k][QB-2:0], 1'b1};
          end else begin
            drem_q[j][k] <= RT_N'(rsh[k]);
            dq_q[j][k]   <= {dq_q[j-1][k][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        if (dzero_q[QB]) begin
          unit_q[k] <= '0;
        end else if (dneg_q[QB][k]) begin
          unit_q[k] <= ~UNIT_W'(dq_q[QB][k]) + UNIT_W'(1);
        end else begin
          unit_q[k] <= UNIT_W'(dq_q[QB][k]);
        end
      end
    end
  end

  assign unit_o = unit_q;
endmodule

// File: design/lacam_cross.sv
// Two-stage registered cross product of two unit vectors.
`timescale 1ns / 1ps
module lacam_cross (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [2:0][lacam_pkg::UNIT_W-1:0]  a_i,
  input  logic [2:0][lacam_pkg::UNIT_W-1:0]  b_i,
  output logic [2:0][lacam_pkg::NIN_W-1:0]   c_o
);
  import lacam_pkg::*;

  localparam int P_W = 2 * UNIT_W;

  logic signed [UNIT_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [P_W-1:0]    p_q [6];
  logic [2:0][NIN_W-1:0]    c_q;

  assign ax = $signed(a_i[0]);
  assign ay = $signed(a_i[1]);
  assign az = $signed(a_i[2]);
  assign bx = $signed(b_i[0]);
  assign by = $signed(b_i[1]);
  assign bz = $signed(b_i[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= P_W'(ay * bz);
      p_q[1] <= P_W'(az * by);
      p_q[2] <= P_W'(az * bx);
      p_q[3] <= P_W'(ax * bz);
      p_q[4] <= P_W'(ax * by);
      p_q[5] <= P_W'(ay * bx);
      c_q[0] <= NIN_W'(p_q[0] - p_q[1]);
      c_q[1] <= NIN_W'(p_q[2] - p_q[3]);
      c_q[2] <= NIN_W'(p_q[4] - p_q[5]);
    end
  end

  assign c_o = c_q;
endmodule

// File: design/lacam_pipe.sv
// Valid and side data delay line matched to the normalizer latency.
`timescale 1ns / 1ps
module lacam_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lacam_pkg::carry_t data_i,
  output logic              valid_o,
  output lacam_pkg::carry_t data_o
);
  import lacam_pkg::*;

  logic [NORM_LAT-1:0] v_q;
  carry_t              d_q [NORM_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NORM_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= data_i;
      for (int k = 1; k < NORM_LAT; k++) begin
        d_q[k] <= d_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NORM_LAT-1];
  assign data_o  = d_q[NORM_LAT-1];
endmodule

// File: design/look_at_camera_transform_core.sv
// Look-at camera transform, one request per cycle through a stalling pipeline.
// Throughput: one request per cycle; each normalizer resolves one root bit per root
// stage and one quotient bit per divide stage. The whole pipe holds only while a result waits.
// Reset clears valid bits only; data registers are not reset.
`timescale 1ns / 1ps
module look_at_camera_transform_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [lacam_pkg::WORD_W-1:0]  point_x_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  point_y_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  point_z_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  cam_pos_x_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  cam_pos_y_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  cam_pos_z_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  target_x_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  target_y_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  target_z_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  up_dir_x_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  up_dir_y_i,
  input  logic signed [lacam_pkg::WORD_W-1:0]  up_dir_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lacam_pkg::WORD_W-1:0]  out_x_o,
  output logic signed [lacam_pkg::WORD_W-1:0]  out_y_o,
  output logic signed [lacam_pkg::WORD_W-1:0]  out_z_o
);
  import lacam_pkg::*;

  localparam logic signed [NIN_W:0]   RND5 = $signed((NIN_W + 1)'(1) << (UNIT_SH - 1));
  localparam logic signed [DIF_W-1:0] RND8 = $signed(DIF_W'(1) << (UNIT_SH - 1));
  localparam logic signed [DIF_W-1:0] SAT_HI =
    $signed({{(DIF_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}});
  localparam logic signed [DIF_W-1:0] SAT_LO = ~SAT_HI;

  logic                   en;
  logic [2:0][NIN_W-1:0]  up_v, lk_v;
  carry_t                 a_in, a_d, b_d;
  logic                   a_v, b_v;
  logic [2:0][UNIT_W-1:0] uu_a, lk_a, lf_b;
  logic [2:0][NIN_W-1:0]  left_raw, up_raw;
  logic                   v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, out_v_q;
  carry_t                 s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [2:0][UNIT_W-1:0] lf3_q, lf4_q, lf5_q;
  logic signed [UP_W-1:0] up5_q [3];
  logic signed [NIN_W:0]  up_t [3];
  logic signed [WORD_W-1:0] px5 [3];
  logic signed [WORD_W-1:0] ps5 [3];
  logic signed [UNIT_W-1:0] lk5 [3];
  logic signed [UNIT_W-1:0] lf5 [3];
  logic signed [PR_W-1:0] tl6_q [3];
  logic signed [PR_W-1:0] tu6_q [3];
  logic signed [PR_W-1:0] tk6_q [3];
  logic signed [PR_W-1:0] ml6_q [3];
  logic signed [PR_W-1:0] mu6_q [3];
  logic signed [PR_W-1:0] mf6_q [3];
  logic signed [SUM_W-1:0] ts7_q [3];
  logic signed [SUM_W-1:0] os7_q [3];
  logic signed [DIF_W-1:0] d8 [3];
  logic signed [DIF_W-1:0] r8_q [3];
  logic [WORD_W-1:0]       out_q [3];

  assign en         = ~out_v_q | out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    up_v[0] = NIN_W'(up_dir_x_i);
    up_v[1] = NIN_W'(up_dir_y_i);
    up_v[2] = NIN_W'(up_dir_z_i);
    lk_v[0] = NIN_W'(target_x_i - cam_pos_x_i);
    lk_v[1] = NIN_W'(target_y_i - cam_pos_y_i);
    lk_v[2] = NIN_W'(target_z_i - cam_pos_z_i);
    a_in.pt[0]  = point_x_i;
    a_in.pt[1]  = point_y_i;
    a_in.pt[2]  = point_z_i;
    a_in.pos[0] = cam_pos_x_i;
    a_in.pos[1] = cam_pos_y_i;
    a_in.pos[2] = cam_pos_z_i;
    a_in.lk     = '0;
  end

  lacam_pipe u_pipe_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .data_i(a_in),
    .valid_o(a_v), .data_o(a_d)
  );

  lacam_norm u_norm_up (.clk_i, .en_i(en), .vec_i(up_v), .unit_o(uu_a));
  lacam_norm u_norm_lk (.clk_i, .en_i(en), .vec_i(lk_v), .unit_o(lk_a));

  lacam_cross u_cross_left (.clk_i, .en_i(en), .a_i(uu_a), .b_i(lk_a), .c_o(left_raw));

  lacam_pipe u_pipe_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .data_i(s2_q),
    .valid_o(b_v), .data_o(b_d)
  );

  lacam_norm u_norm_left (.clk_i, .en_i(en), .vec_i(left_raw), .unit_o(lf_b));

  lacam_cross u_cross_up (.clk_i, .en_i(en), .a_i(b_d.lk), .b_i(lf_b), .c_o(up_raw));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= a_v;
      v2_q    <= v1_q;
      v3_q    <= b_v;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      out_v_q <= v8_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      up_t[k] = $signed({up_raw[k][NIN_W-1], up_raw[k]}) + RND5;
      px5[k]  = $signed(s5_q.pt[k]);
      ps5[k]  = $signed(s5_q.pos[k]);
      lk5[k]  = $signed(s5_q.lk[k]);
      lf5[k]  = $signed(lf5_q[k]);
      d8[k]   = DIF_W'(ts7_q[k]) - DIF_W'(os7_q[k]) + RND8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.pt  <= a_d.pt;
      s1_q.pos <= a_d.pos;
      s1_q.lk  <= lk_a;
      s2_q     <= s1_q;
      s3_q     <= b_d;
      lf3_q    <= lf_b;
      s4_q     <= s3_q;
      lf4_q    <= lf3_q;
      s5_q     <= s4_q;
      lf5_q    <= lf4_q;
      for (int k = 0; k < 3; k++) begin
        up5_q[k] <= UP_W'(up_t[k] >>> UNIT_SH);
        tl6_q[k] <= PR_W'(ps5[k] * lf5[k]);
        tu6_q[k] <= PR_W'(ps5[k] * up5_q[k]);
        tk6_q[k] <= PR_W'(ps5[k] * lk5[k]);
        ml6_q[k] <= PR_W'(lk5[k] * px5[2]);
        mu6_q[k] <= PR_W'(up5_q[k] * px5[1]);
        mf6_q[k] <= PR_W'(lf5[k] * px5[0]);
        ts7_q[k] <= SUM_W'(ml6_q[k]) + SUM_W'(mu6_q[k]) + SUM_W'(mf6_q[k]);
        r8_q[k]  <= d8[k] >>> UNIT_SH;
        if (r8_q[k] > SAT_HI) begin
          out_q[k] <= SAT_HI[WORD_W-1:0];
        end else if (r8_q[k] < SAT_LO) begin
          out_q[k] <= SAT_LO[WORD_W-1:0];
        end else begin
          out_q[k] <= r8_q[k][WORD_W-1:0];
        end
      end
      os7_q[0] <= SUM_W'(tl6_q[0]) + SUM_W'(tl6_q[1]) + SUM_W'(tl6_q[2]);
      os7_q[1] <= SUM_W'(tu6_q[0]) + SUM_W'(tu6_q[1]) + SUM_W'(tu6_q[2]);
      os7_q[2] <= SUM_W'(tk6_q[0]) + SUM_W'(tk6_q[1]) + SUM_W'(tk6_q[2]);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
endmodule

// File: design/lacam_check.sv
// Port-level checker for the camera transform core, bound to the top level.
`timescale 1ns / 1ps
module lacam_check (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [lacam_pkg::WORD_W-1:0] out_x_o,
  input logic signed [lacam_pkg::WORD_W-1:0] out_y_o,
  input logic signed [lacam_pkg::WORD_W-1:0] out_z_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without a pending result");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");
endmodule

bind look_at_camera_transform_core lacam_check u_lacam_check (.*);

// File: test/look_at_camera_transform_core_test.sv
// Self-checking testbench for the look-at camera transform with random flow control.
`timescale 1ns / 1ps
module look_at_camera_transform_core_test;
  import lacam_pkg::*;

  localparam int  N_RANDOM  = 550;
  localparam int  DRAIN_AT  = 300;
  localparam int  MAX_CYCLE = 400000;
  localparam int  TAIL      = 2 * NORM_LAT + 40;

  typedef logic signed [127:0] wide_t;
  typedef logic [11:0][WORD_W-1:0] cam_req_t;
  typedef logic [2:0][WORD_W-1:0] cam_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic signed [WORD_W-1:0] out_x_o, out_y_o, out_z_o;
  cam_req_t drv = '0;

  cam_req_t pending_q[$];
  cam_pt_t  expected_pts[$];
  logic     in_taken = 1'b0;
  int       burst_left = 8, gap_left = 0, sent = 0, got = 0, cycles = 0;
  int       mismatches = 0;
  bit       drain_active = 0, drain_done = 0;
  int       rx_mode = 0;

  look_at_camera_transform_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .point_x_i(drv[0]), .point_y_i(drv[1]), .point_z_i(drv[2]),
    .cam_pos_x_i(drv[3]), .cam_pos_y_i(drv[4]), .cam_pos_z_i(drv[5]),
    .target_x_i(drv[6]), .target_y_i(drv[7]), .target_z_i(drv[8]),
    .up_dir_x_i(drv[9]), .up_dir_y_i(drv[10]), .up_dir_z_i(drv[11]),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint signed sext_word(logic [WORD_W-1:0] w);
    logic signed [WORD_W-1:0] s;
    s = w;
    return longint'(s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(inout longint signed v[3]);
    longint unsigned mag[3];
    bit neg[3];
    longint unsigned m, sum, n, q;
    int s;
    m = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'd0 - v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return;
    while (m >= (64'd1 << LIM_W)) begin
      m = m >> 1;
      s++;
    end
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum += mag[i] * mag[i];
    end
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << UNIT_SH) + n / 2) / n;
      v[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic wide_t round_unit(wide_t v);
    return (v + (wide_t'(1) <<< (UNIT_SH - 1))) >>> UNIT_SH;
  endfunction

  function automatic wide_t mul(longint signed a, longint signed b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic cam_pt_t transform_point(cam_req_t r);
    longint signed pt[3], pos[3], lk[3], up[3], lf[3];
    wide_t off[3], acc, hi, lo;
    cam_pt_t res;
    hi = (wide_t'(1) <<< (WORD_W - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      pt[i]  = sext_word(r[i]);
      pos[i] = sext_word(r[3+i]);
      lk[i]  = sext_word(r[6+i]) - pos[i];
      up[i]  = sext_word(r[9+i]);
    end
    unit_vec(up);
    unit_vec(lk);
    lf[0] = up[1] * lk[2] - up[2] * lk[1];
    lf[1] = up[2] * lk[0] - up[0] * lk[2];
    lf[2] = up[0] * lk[1] - up[1] * lk[0];
    unit_vec(lf);
    up[0] = longint'(round_unit(mul(lk[1], lf[2]) - mul(lk[2], lf[1])));
    up[1] = longint'(round_unit(mul(lk[2], lf[0]) - mul(lk[0], lf[2])));
    up[2] = longint'(round_unit(mul(lk[0], lf[1]) - mul(lk[1], lf[0])));
    off[0] = mul(pos[0], lf[0]) + mul(pos[1], lf[1]) + mul(pos[2], lf[2]);
    off[1] = mul(pos[0], up[0]) + mul(pos[1], up[1]) + mul(pos[2], up[2]);
    off[2] = mul(pos[0], lk[0]) + mul(pos[1], lk[1]) + mul(pos[2], lk[2]);
    for (int i = 0; i < 3; i++) begin
      acc = round_unit(mul(lk[i], pt[2]) + mul(up[i], pt[1]) + mul(lf[i], pt[0]) - off[i]);
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
      res[i] = acc[WORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] near_word(int span);
    return WORD_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic cam_req_t random_req();
    cam_req_t r;
    int kind, span, k;
    kind = $urandom_range(0, 9);
    span = (kind < 6) ? (1 << $urandom_range(8, 24)) : 0;
    for (int i = 0; i < 12; i++)
      r[i] = (kind >= 6) ? WORD_W'($urandom) : near_word(span);
    case (kind)
      1: r[11:9] = '0;
      2: r[8:6] = r[5:3];
      3: begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < 3; i++) r[9+i] = (r[6+i] - r[3+i]) * k;
      end
      9: for (int i = 0; i < 12; i++) r[i] = $urandom_range(0, 1) ? '1 << (WORD_W - 1) : '1 >> 1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_dir(logic [WORD_W-1:0] p, logic [WORD_W-1:0] c,
                         logic [WORD_W-1:0] t, logic [WORD_W-1:0] u);
    cam_req_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = p;
      r[3+i] = c;
      r[6+i] = t;
      r[9+i] = u;
    end
    pending_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) expected_pts.push_back(transform_point(drv));
    if (out_valid_o && out_ready_i) begin
      got <= got + 1;
      if (expected_pts.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h %h %h", out_x_o, out_y_o, out_z_o);
      end else begin
        cam_pt_t e;
        e = expected_pts.pop_front();
        if (e[0] !== out_x_o || e[1] !== out_y_o || e[2] !== out_z_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result %0d: expected %h %h %h, got %h %h %h", got,
                     e[0], e[1], e[2], out_x_o, out_y_o, out_z_o);
        end
      end
    end
    if (cycles > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (sent == DRAIN_AT && !drain_done) begin
          drain_active = 1;
          if (expected_pts.size() == 0 && !in_valid_i) drain_done = 1;
        end
        if (pending_q.size() > 0 && gap_left == 0 && !(drain_active && !drain_done)) begin
          drv <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          sent = sent + 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
      if (cycles % 97 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (cycles % 16) < 4;
      endcase
    end
  end

  initial begin
    add_dir('0, '0, '0, '0);
    add_dir(32'h0001_0000, '0, 32'h0001_0000, 32'h0001_0000);
    add_dir('1 >> 1, '0, '1 >> 1, '1 >> 1);
    add_dir('1 << 31, '0, '1 << 31, '1 << 31);
    add_dir('1 >> 1, '1 << 31, '1 >> 1, '1);
    add_dir('1 << 31, '1 >> 1, '1 << 31, 32'h0000_0001);
    add_dir('1, '1, '1, '1);
    add_dir(32'h0003_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000);
    add_dir(32'h0003_0000, 32'h0001_0000, 32'h0005_0000, '0);
    add_dir(32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000);
    add_dir(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    add_dir('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1);
    pending_q.push_back({32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                         32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000});
    pending_q.push_back({32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0,
                         32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    for (int i = 0; i < N_RANDOM; i++) pending_q.push_back(random_req());
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i && expected_pts.size() == 0);
    repeat (TAIL) @(posedge clk_i);
    $display("ran %0d camera transforms: extremes, degenerate axes, saturation", sent);
    $display("%0d results checked, %0d mismatches, %0d cycles", got, mismatches, cycles);
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
